FILE: sv/lbpd_pkg.sv
// Package for the signal tower, buzzer and indicator channel driver.
// Holds command codes, action codes, the item type and the buzzer pattern ROM.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package lbpd_pkg;

   localparam int NUM_CHANNELS_DEFAULT  = 30;
   localparam int PATTERN_STEPS_DEFAULT = 30;
   localparam int LEVELS_W              = 30;

   localparam logic [7:0] BLINK_PERIOD_RESET = 8'd7;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_TOWER   = 2'd1,
      CMD_CHANNEL = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   localparam logic [2:0] TOWER_OFF         = 3'd0;
   localparam logic [2:0] TOWER_ON          = 3'd1;
   localparam logic [2:0] TOWER_BLINK_FIRST = 3'd2;
   localparam logic [2:0] TOWER_BLINK_LAST  = 3'd4;
   localparam logic [2:0] TOWER_IDLE        = 3'd7;

   localparam logic [2:0] COLOR_CLEAR  = 3'd0;
   localparam logic [2:0] COLOR_RED    = 3'd1;
   localparam logic [2:0] COLOR_GREEN  = 3'd2;
   localparam logic [2:0] COLOR_YELLOW = 3'd4;

   localparam logic [3:0] BUZZ_OFF      = 4'd0;
   localparam logic [3:0] BUZZ_ON       = 4'd1;
   localparam logic [3:0] BUZZ_PAT_LAST = 4'd7;
   localparam logic [3:0] BUZZ_IDLE     = 4'd15;

   localparam logic [1:0] CH_OFF   = 2'd0;
   localparam logic [1:0] CH_ON    = 2'd1;
   localparam logic [1:0] CH_BLINK = 2'd2;
   localparam logic [1:0] CH_IDLE  = 2'd3;

   typedef struct packed {
      cmd_type    command;
      logic [2:0] tower_action;
      logic [2:0] tower_color;
      logic [3:0] buzzer_pattern;
      logic [5:0] channel;
      logic [1:0] channel_action;
   } item_type;

   // Row n is buzzer pattern n; the leftmost digit is step 0.
   localparam logic [0:31] PATTERN_ROM [8] = '{
      32'b0000000000_0000000000_0000000000_00,
      32'b0000000000_0000000000_0000000000_00,
      32'b1111111000_1111111000_1111111000_00,
      32'b1111100000_1111100000_1111100000_00,
      32'b1110000000_1110000000_1110000000_00,
      32'b1110001110_0011100011_1000111000_00,
      32'b1111111111_0000011111_1111100000_00,
      32'b1111100001_1110001110_0011001100_00
   };

   function automatic logic pattern_bit(input logic [2:0] pat, input logic [4:0] step);
      logic [0:31] row;
      row = PATTERN_ROM[pat];
      return row[step];
   endfunction

   // Returns {red, green}; unknown colour codes keep the current lamps.
   function automatic logic [1:0] lamp_decode(input logic [2:0] colour,
                                               input logic [1:0] cur);
      logic [1:0] rg;
      case (colour)
         COLOR_CLEAR:  rg = 2'b00;
         COLOR_RED:    rg = 2'b10;
         COLOR_GREEN:  rg = 2'b01;
         COLOR_YELLOW: rg = 2'b11;
         default:      rg = cur;
      endcase
      return rg;
   endfunction

endpackage

FILE: sv/lbpd_ifs.sv
// Channel interfaces of the tower/buzzer/channel driver: request, response
// and register write channels. Depends on lbpd_pkg.
`timescale 1ns / 1ps

interface lbpd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [2:0] tower_action;
   logic [2:0] tower_color;
   logic [3:0] buzzer_pattern;
   logic [5:0] channel;
   logic [1:0] channel_action;

   modport source (output valid, command, tower_action, tower_color, buzzer_pattern,
                   channel, channel_action, input ready);
   modport sink (input valid, command, tower_action, tower_color, buzzer_pattern,
                 channel, channel_action, output ready);
endinterface

interface lbpd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lbpd_pkg::LEVELS_W-1:0] channel_levels;
   logic                          lamp_red;
   logic                          lamp_green;
   logic                          lamp_blue;
   logic                          buzzer_on;

   modport source (output valid, channel_levels, lamp_red, lamp_green, lamp_blue,
                   buzzer_on, input ready);
   modport sink (input valid, channel_levels, lamp_red, lamp_green, lamp_blue,
                 buzzer_on, output ready);
endinterface

interface lbpd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: sv/lbpd_tower_buzz.sv
// Blink timer, signal tower lamps and buzzer pattern sequencer.
// Depends on lbpd_pkg.
`timescale 1ns / 1ps

module lbpd_tower_buzz #(
   parameter int PATTERN_STEPS = lbpd_pkg::PATTERN_STEPS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  lbpd_pkg::item_type item,
   input  logic [7:0]         blink_period,
   output logic               blink_phase,
   output logic               lamp_red,
   output logic               lamp_green,
   output logic               buzzer_on
);
   import lbpd_pkg::*;

   logic [7:0] count_ff, count_in, count_inc;
   logic       phase_ff, phase_in;
   logic [2:0] tower_mode_ff, tower_mode_in;
   logic [2:0] colour_ff, colour_in;
   logic [3:0] buzz_mode_ff, buzz_mode_in;
   logic [4:0] step_ff, step_in, step_cur;
   logic [1:0] rg_ff, rg_in;
   logic       buzz_ff, buzz_in;

   always_comb begin
      count_in      = count_ff;
      phase_in      = phase_ff;
      tower_mode_in = tower_mode_ff;
      colour_in     = colour_ff;
      buzz_mode_in  = buzz_mode_ff;
      step_in       = step_ff;
      rg_in         = rg_ff;
      buzz_in       = buzz_ff;
      count_inc     = count_ff + 8'd1;
      step_cur      = ({1'b0, step_ff} >= 6'(PATTERN_STEPS)) ? 5'd0 : step_ff;
      if (fire) begin
         unique case (item.command)
            CMD_TICK: begin
               if (count_inc >= blink_period) begin
                  phase_in = ~phase_ff;
                  count_in = 8'd0;
               end else begin
                  count_in = count_inc;
               end
               if (tower_mode_ff == TOWER_OFF) begin
                  rg_in         = lamp_decode(COLOR_CLEAR, rg_ff);
                  tower_mode_in = TOWER_IDLE;
               end else if (tower_mode_ff == TOWER_ON) begin
                  rg_in         = lamp_decode(colour_ff, rg_ff);
                  tower_mode_in = TOWER_IDLE;
               end else if (tower_mode_ff >= TOWER_BLINK_FIRST &&
                            tower_mode_ff <= TOWER_BLINK_LAST) begin
                  rg_in = lamp_decode(phase_in ? colour_ff : COLOR_CLEAR, rg_ff);
               end
               if (buzz_mode_ff <= BUZZ_ON) begin
                  buzz_in      = buzz_mode_ff[0];
                  buzz_mode_in = BUZZ_IDLE;
               end else if (buzz_mode_ff <= BUZZ_PAT_LAST) begin
                  buzz_in = pattern_bit(buzz_mode_ff[2:0], step_cur);
                  step_in = step_cur + 5'd1;
               end
            end
            CMD_TOWER: begin
               tower_mode_in = item.tower_action;
               colour_in     = item.tower_color;
               buzz_mode_in  = item.buzzer_pattern;
               if (item.tower_action == TOWER_ON) begin
                  rg_in = lamp_decode(item.tower_color, rg_ff);
               end else if (item.tower_action <= TOWER_BLINK_LAST) begin
                  rg_in = lamp_decode(COLOR_CLEAR, rg_ff);
               end
               if (item.buzzer_pattern == BUZZ_OFF) begin
                  buzz_in = 1'b0;
               end else if (item.buzzer_pattern == BUZZ_ON) begin
                  buzz_in = 1'b1;
               end else if (item.buzzer_pattern <= BUZZ_PAT_LAST) begin
                  step_in = 5'd0;
                  buzz_in = 1'b0;
               end
            end
            CMD_CHANNEL, CMD_NONE: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= 8'd0;
         phase_ff      <= 1'b0;
         tower_mode_ff <= TOWER_IDLE;
         colour_ff     <= COLOR_CLEAR;
         buzz_mode_ff  <= BUZZ_IDLE;
         step_ff       <= 5'(PATTERN_STEPS);
         rg_ff         <= 2'b00;
         buzz_ff       <= 1'b0;
      end else begin
         count_ff      <= count_in;
         phase_ff      <= phase_in;
         tower_mode_ff <= tower_mode_in;
         colour_ff     <= colour_in;
         buzz_mode_ff  <= buzz_mode_in;
         step_ff       <= step_in;
         rg_ff         <= rg_in;
         buzz_ff       <= buzz_in;
      end
   end

   // Channels blinking on this beat must see the phase after the tick.
   assign blink_phase = phase_in;
   assign lamp_red    = rg_ff[1];
   assign lamp_green  = rg_ff[0];
   assign buzzer_on   = buzz_ff;

   a_one_shot_tower: assert property (@(posedge clock) disable iff (reset)
      fire && item.command == CMD_TICK && tower_mode_ff <= TOWER_ON
      |=> tower_mode_ff == TOWER_IDLE)
      else $error("one-shot tower mode did not return to idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fire && item.command == CMD_TICK
      |=> count_ff == 8'd0 || count_ff < $past(blink_period))
      else $error("blink count passed the period");

   a_phase_on_tick: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && phase_ff != $past(phase_ff)
      |-> $past(fire) && $past(item.command) == CMD_TICK)
      else $error("blink phase changed without a tick");

endmodule

FILE: sv/lbpd_chan_bank.sv
// Indicator channel bank: one stored action and one output level per channel.
// Depends on lbpd_pkg.
`timescale 1ns / 1ps

module lbpd_chan_bank #(
   parameter int NUM_CHANNELS = lbpd_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  lbpd_pkg::item_type            item,
   input  logic                          blink_phase,
   output logic [lbpd_pkg::LEVELS_W-1:0] channel_levels
);
   import lbpd_pkg::*;

   logic [1:0]              req_ff [NUM_CHANNELS];
   logic [1:0]              req_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] level_ff, level_in;

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
      always_comb begin
         req_in[i]   = req_ff[i];
         level_in[i] = level_ff[i];
         if (fire) begin
            unique case (item.command)
               CMD_TICK: begin
                  if (req_ff[i] == CH_OFF || req_ff[i] == CH_ON) begin
                     level_in[i] = req_ff[i][0];
                     req_in[i]   = CH_IDLE;
                  end else if (req_ff[i] == CH_BLINK) begin
                     level_in[i] = blink_phase;
                  end
               end
               CMD_CHANNEL: begin
                  // Channel numbers past the last channel match no entry.
                  if (item.channel == 6'(i)) begin
                     req_in[i] = item.channel_action;
                     if (item.channel_action == CH_OFF || item.channel_action == CH_ON) begin
                        level_in[i] = item.channel_action[0];
                     end else if (item.channel_action == CH_BLINK) begin
                        level_in[i] = blink_phase;
                     end
                  end
               end
               CMD_TOWER, CMD_NONE: begin
               end
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            req_ff[i]   <= CH_IDLE;
            level_ff[i] <= 1'b0;
         end else begin
            req_ff[i]   <= req_in[i];
            level_ff[i] <= level_in[i];
         end
      end
   end

   for (genvar i = 0; i < LEVELS_W; i++) begin : g_out
      if (i < NUM_CHANNELS) begin : g_used
         assign channel_levels[i] = level_ff[i];
      end else begin : g_unused
         assign channel_levels[i] = 1'b0;
      end
   end

endmodule

FILE: sv/lamp_led_buzzer_pattern_driver_core.sv
// Top level of the signal tower, buzzer and indicator channel driver.
// Depends on lbpd_pkg, lbpd_ifs, lbpd_tower_buzz and lbpd_chan_bank.
`timescale 1ns / 1ps

// Each request beat (tick, tower/buzzer request, channel request or CMD_NONE)
// yields exactly one response beat holding every output level. A beat is
// captured in an input register and processed from there into the state
// registers, which drive the response; one beat per cycle is sustained while
// the response is not stalled. The state registers themselves form the
// response register: while a response is stalled the input register still
// takes one more beat. blink_period is written through the csr channel,
// which is always ready; write it only while no beat is in flight.

module lamp_led_buzzer_pattern_driver_core #(
   parameter int NUM_CHANNELS  = lbpd_pkg::NUM_CHANNELS_DEFAULT,
   parameter int PATTERN_STEPS = lbpd_pkg::PATTERN_STEPS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   lbpd_req_if.sink   req_bus,
   lbpd_rsp_if.source rsp_bus,
   lbpd_csr_if.sink   csr_bus
);
   import lbpd_pkg::*;

   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] period_ff, period_in;
   logic       advance;
   logic       blink_phase;

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff;
      if (req_bus.valid && req_bus.ready) begin
         item_in.command        = cmd_type'(req_bus.command);
         item_in.tower_action   = req_bus.tower_action;
         item_in.tower_color    = req_bus.tower_color;
         item_in.buzzer_pattern = req_bus.buzzer_pattern;
         item_in.channel        = req_bus.channel;
         item_in.channel_action = req_bus.channel_action;
         in_valid_in            = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      period_in = (csr_bus.valid && csr_bus.ready) ? csr_bus.data : period_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= BLINK_PERIOD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   lbpd_tower_buzz #(
      .PATTERN_STEPS (PATTERN_STEPS)
   ) u_tower_buzz (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .item         (item_ff),
      .blink_period (period_ff),
      .blink_phase  (blink_phase),
      .lamp_red     (rsp_bus.lamp_red),
      .lamp_green   (rsp_bus.lamp_green),
      .buzzer_on    (rsp_bus.buzzer_on)
   );

   lbpd_chan_bank #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_chan_bank (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .item           (item_ff),
      .blink_phase    (blink_phase),
      .channel_levels (rsp_bus.channel_levels)
   );

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.lamp_blue = 1'b0;

   a_advance_responds: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed beat produced no response");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> in_valid_ff && rsp_valid_ff && !rsp_bus.ready)
      else $error("request stalled without a blocked response");

   a_levels_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready
      |=> $stable({rsp_bus.channel_levels, rsp_bus.lamp_red, rsp_bus.lamp_green,
                   rsp_bus.buzzer_on}))
      else $error("output levels changed under a stalled response");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the signal tower, buzzer and indicator channel driver.
// A scoreboard class predicts every response beat; tasks drive the request and csr channels.
// Depends on lbpd_pkg, lbpd_ifs and lamp_led_buzzer_pattern_driver_core.
`timescale 1ns / 1ps

module testbench;
   import lbpd_pkg::*;

   localparam int CHANNELS = NUM_CHANNELS_DEFAULT;
   localparam int STEPS    = PATTERN_STEPS_DEFAULT;

   typedef struct packed {
      logic [LEVELS_W-1:0] chans;
      logic                red;
      logic                green;
      logic                blue;
      logic                buzz;
   } levels_type;

   class lamp_scoreboard;
      bit [7:0]          period;
      bit [7:0]          count;
      bit                phase;
      bit [2:0]          tower_mode;
      bit [2:0]          colour;
      bit [3:0]          buzz_mode;
      bit [4:0]          step;
      bit [1:0]          chan_req [CHANNELS];
      bit [CHANNELS-1:0] chans;
      bit                red;
      bit                green;
      bit                buzz;
      levels_type        levels_due [$];
      int                fails;

      function new();
         period     = BLINK_PERIOD_RESET;
         count      = '0;
         phase      = 1'b0;
         tower_mode = TOWER_IDLE;
         colour     = COLOR_CLEAR;
         buzz_mode  = BUZZ_IDLE;
         step       = 5'(STEPS);
         foreach (chan_req[i]) chan_req[i] = CH_IDLE;
         chans      = '0;
         red        = 1'b0;
         green      = 1'b0;
         buzz       = 1'b0;
         fails      = 0;
      endfunction

      function void report(string what, logic [31:0] want, logic [31:0] got);
         $display("mismatch: %s, expected %0h, got %0h", what, want, got);
         fails++;
      endfunction

      // Step 0 is the leftmost digit; the last two positions are always silent.
      function bit rom_bit(bit [2:0] pat, bit [4:0] idx);
         bit [0:31] row;
         case (pat)
            3'd2:    row = 32'b1111111000_1111111000_1111111000_00;
            3'd3:    row = 32'b1111100000_1111100000_1111100000_00;
            3'd4:    row = 32'b1110000000_1110000000_1110000000_00;
            3'd5:    row = 32'b1110001110_0011100011_1000111000_00;
            3'd6:    row = 32'b1111111111_0000011111_1111100000_00;
            3'd7:    row = 32'b1111100001_1110001110_0011001100_00;
            default: row = '0;
         endcase
         return row[idx];
      endfunction

      function void show_colour(bit [2:0] c);
         case (c)
            COLOR_CLEAR:  {red, green} = 2'b00;
            COLOR_RED:    {red, green} = 2'b10;
            COLOR_GREEN:  {red, green} = 2'b01;
            COLOR_YELLOW: {red, green} = 2'b11;
            default: ;
         endcase
      endfunction

      function void tick();
         count = count + 8'd1;
         if (count >= period) begin
            phase = ~phase;
            count = '0;
         end
         if (tower_mode == TOWER_OFF) begin
            show_colour(COLOR_CLEAR);
            tower_mode = TOWER_IDLE;
         end else if (tower_mode == TOWER_ON) begin
            show_colour(colour);
            tower_mode = TOWER_IDLE;
         end else if (tower_mode >= TOWER_BLINK_FIRST && tower_mode <= TOWER_BLINK_LAST) begin
            show_colour(phase ? colour : COLOR_CLEAR);
         end
         if (buzz_mode <= BUZZ_ON) begin
            buzz      = buzz_mode[0];
            buzz_mode = BUZZ_IDLE;
         end else if (buzz_mode <= BUZZ_PAT_LAST) begin
            if (step >= STEPS) step = '0;
            buzz = rom_bit(buzz_mode[2:0], step);
            step = step + 5'd1;
         end
         for (int i = 0; i < CHANNELS; i++) begin
            if (chan_req[i] <= CH_ON) begin
               chans[i]    = chan_req[i][0];
               chan_req[i] = CH_IDLE;
            end else if (chan_req[i] == CH_BLINK) begin
               chans[i] = phase;
            end
         end
      endfunction

      function void note_command(item_type it);
         levels_type lv;
         case (it.command)
            CMD_TICK: tick();
            CMD_TOWER: begin
               tower_mode = it.tower_action;
               colour     = it.tower_color;
               buzz_mode  = it.buzzer_pattern;
               // A blink request starts with the lamps dark.
               if (it.tower_action == TOWER_ON) show_colour(it.tower_color);
               else if (it.tower_action <= TOWER_BLINK_LAST) show_colour(COLOR_CLEAR);
               if (it.buzzer_pattern == BUZZ_OFF) begin
                  buzz = 1'b0;
               end else if (it.buzzer_pattern == BUZZ_ON) begin
                  buzz = 1'b1;
               end else if (it.buzzer_pattern <= BUZZ_PAT_LAST) begin
                  step = '0;
                  buzz = 1'b0;
               end
            end
            CMD_CHANNEL: begin
               if (it.channel < CHANNELS) begin
                  chan_req[it.channel] = it.channel_action;
                  if (it.channel_action <= CH_ON) chans[it.channel] = it.channel_action[0];
                  else if (it.channel_action == CH_BLINK) chans[it.channel] = phase;
               end
            end
            default: ;
         endcase
         lv.chans = chans;
         lv.red   = red;
         lv.green = green;
         lv.blue  = 1'b0;
         lv.buzz  = buzz;
         levels_due.push_back(lv);
      endfunction

      function void check_levels(levels_type got);
         levels_type want;
         if (levels_due.size() == 0) begin
            report("response beat with nothing pending", 32'h0, 32'(got));
            return;
         end
         want = levels_due.pop_front();
         if (want.chans !== got.chans) report("channel_levels", 32'(want.chans), 32'(got.chans));
         if (want.red !== got.red) report("lamp_red", 32'(want.red), 32'(got.red));
         if (want.green !== got.green) report("lamp_green", 32'(want.green), 32'(got.green));
         if (want.blue !== got.blue) report("lamp_blue", 32'(want.blue), 32'(got.blue));
         if (want.buzz !== got.buzz) report("buzzer_on", 32'(want.buzz), 32'(got.buzz));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   lbpd_req_if req_bus ();
   lbpd_rsp_if rsp_bus ();
   lbpd_csr_if csr_bus ();

   lamp_led_buzzer_pattern_driver_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   lamp_scoreboard sb = new();

   bit calm       = 1'b0;
   int hold_asked = 0;

   always #1 clock = ~clock;

   initial begin
      #200000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Response side: checks each beat and decides ready for the next edge.
   initial begin
      int         hold_seen;
      int         hold_left;
      levels_type got;
      hold_seen     = 0;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.chans = rsp_bus.channel_levels;
            got.red   = rsp_bus.lamp_red;
            got.green = rsp_bus.lamp_green;
            got.blue  = rsp_bus.lamp_blue;
            got.buzz  = rsp_bus.buzzer_on;
            sb.check_levels(got);
         end
         if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = 60;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= 32);
         end
      end
   end

   task automatic send_item(input item_type it);
      req_bus.valid          <= 1'b1;
      req_bus.command        <= it.command;
      req_bus.tower_action   <= it.tower_action;
      req_bus.tower_color    <= it.tower_color;
      req_bus.buzzer_pattern <= it.buzzer_pattern;
      req_bus.channel        <= it.channel;
      req_bus.channel_action <= it.channel_action;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_command(it);
      if (!calm) begin
         while ($urandom_range(99) < 32) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // Stops requests and waits until every expected beat has arrived.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.levels_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_period(input logic [7:0] value);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      sb.period = value;
   endtask

   function automatic item_type make_item(cmd_type cmd, logic [2:0] ta, logic [2:0] tc,
                                          logic [3:0] bp, logic [5:0] ch, logic [1:0] ca);
      item_type it;
      it.command        = cmd;
      it.tower_action   = ta;
      it.tower_color    = tc;
      it.buzzer_pattern = bp;
      it.channel        = ch;
      it.channel_action = ca;
      return it;
   endfunction

   // Mostly well-formed commands with random content, some raw noise.
   function automatic item_type random_item();
      item_type it;
      int       roll;
      it.command        = cmd_type'($urandom_range(3));
      it.tower_action   = 3'($urandom);
      it.tower_color    = 3'($urandom);
      it.buzzer_pattern = 4'($urandom);
      it.channel        = 6'($urandom);
      it.channel_action = 2'($urandom);
      roll = $urandom_range(99);
      if (roll < 50) begin
         it.command = CMD_TICK;
      end else if (roll < 70) begin
         it.command = CMD_TOWER;
         if ($urandom_range(99) < 80) begin
            it.tower_action   = 3'($urandom_range(TOWER_BLINK_LAST));
            it.buzzer_pattern = 4'($urandom_range(BUZZ_PAT_LAST));
            case ($urandom_range(3))
               0: it.tower_color = COLOR_CLEAR;
               1: it.tower_color = COLOR_RED;
               2: it.tower_color = COLOR_GREEN;
               default: it.tower_color = COLOR_YELLOW;
            endcase
         end
      end else if (roll < 95) begin
         it.command = CMD_CHANNEL;
         if ($urandom_range(99) < 85) it.channel = 6'($urandom_range(CHANNELS - 1));
      end else begin
         it.command = CMD_NONE;
      end
      return it;
   endfunction

   initial begin
      item_type   it;
      logic [7:0] periods [4];
      int         done;
      req_bus.valid          = 1'b0;
      req_bus.command        = '0;
      req_bus.tower_action   = '0;
      req_bus.tower_color    = '0;
      req_bus.buzzer_pattern = '0;
      req_bus.channel        = '0;
      req_bus.channel_action = '0;
      csr_bus.valid          = 1'b0;
      csr_bus.data           = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the fastest blink so the phase flips every tick.
      write_period(8'd1);
      send_item(make_item(CMD_CHANNEL, 3'd0, 3'd0, 4'd0, 6'd0, CH_ON));
      send_item(make_item(CMD_CHANNEL, 3'd7, 3'd7, 4'd15, 6'd29, CH_BLINK));
      send_item(make_item(CMD_CHANNEL, 3'd0, 3'd0, 4'd0, 6'd30, CH_ON));
      send_item(make_item(CMD_CHANNEL, 3'd0, 3'd0, 4'd0, 6'd63, CH_BLINK));
      send_item(make_item(CMD_CHANNEL, 3'd0, 3'd0, 4'd0, 6'd1, CH_IDLE));
      send_item(make_item(CMD_TOWER, TOWER_ON, COLOR_YELLOW, BUZZ_ON, 6'd0, 2'd0));
      send_item(make_item(CMD_TICK, 3'd0, 3'd0, 4'd0, 6'd0, 2'd0));
      send_item(make_item(CMD_TOWER, TOWER_BLINK_FIRST, COLOR_RED, 4'd2, 6'd0, 2'd0));
      repeat (3) send_item(make_item(CMD_TICK, 3'd0, 3'd0, 4'd0, 6'd0, 2'd0));
      send_item(make_item(CMD_TOWER, 3'd3, COLOR_GREEN, BUZZ_PAT_LAST, 6'd0, 2'd0));
      send_item(make_item(CMD_TICK, 3'd0, 3'd0, 4'd0, 6'd0, 2'd0));
      send_item(make_item(CMD_TOWER, TOWER_BLINK_LAST, COLOR_YELLOW, 4'd5, 6'd0, 2'd0));
      send_item(make_item(CMD_TICK, 3'd0, 3'd0, 4'd0, 6'd0, 2'd0));
      send_item(make_item(CMD_TOWER, 3'd5, 3'd3, 4'd8, 6'd0, 2'd0));
      send_item(make_item(CMD_TOWER, TOWER_ON, 3'd6, 4'd6, 6'd0, 2'd0));
      send_item(make_item(CMD_TICK, 3'd0, 3'd0, 4'd0, 6'd0, 2'd0));
      send_item(make_item(CMD_TOWER, TOWER_OFF, COLOR_CLEAR, BUZZ_OFF, 6'd0, 2'd0));
      send_item(make_item(CMD_TICK, 3'd0, 3'd0, 4'd0, 6'd0, 2'd0));
      send_item(make_item(CMD_TOWER, TOWER_IDLE, 3'd7, BUZZ_IDLE, 6'd0, 2'd0));
      send_item(make_item(CMD_CHANNEL, 3'd0, 3'd0, 4'd0, 6'd29, CH_OFF));
      send_item(make_item(CMD_NONE, 3'd7, 3'd7, 4'd15, 6'd63, 2'd3));
      send_item(make_item(CMD_TICK, 3'd0, 3'd0, 4'd0, 6'd0, 2'd0));

      periods[0] = 8'd255;
      periods[1] = 8'($urandom_range(2, 12));
      periods[2] = BLINK_PERIOD_RESET;
      periods[3] = 8'd1;
      for (int p = 0; p < 4; p++) begin
         write_period(periods[p]);
         done = 0;
         while (done < 95) begin
            // Phase-specific pressure: a drained pause, a long response stall, calm traffic.
            if (p == 1 && done == 40) drain();
            if (p == 2 && done == 20) hold_asked++;
            calm = (p == 3 && done < 50);
            it = random_item();
            send_item(it);
            if (!(it.command == CMD_NONE || (it.command == CMD_CHANNEL && it.channel >= CHANNELS)))
               done++;
         end
      end
      calm = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      if (sb.fails == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
